/* design/ppm_stream_to_grayscale_macros.svh */
// Assertion macros used by the PPM grayscale top level.
`ifndef PPM_STREAM_TO_GRAYSCALE_MACROS_SVH
`define PPM_STREAM_TO_GRAYSCALE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PPMG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppm grayscale check failed");

// next-cycle implication, sampled on clk, off during reset
`define PPMG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppm grayscale check failed");

`endif

/* design/ppmgray_pkg.sv */
// Shared types and status codes of the PPM grayscale converter.
package ppmgray_pkg;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_HDR = 2'd1;
	localparam logic [1:0] ST_LEN = 2'd2;

	// up to three results caused by one input item
	typedef struct packed {
		logic [1:0] n;          // number of results, 0..3
		logic [7:0] first_byte; // byte of every result but the final one
		logic [7:0] fin_byte;
		logic       fin_last;
		logic [1:0] fin_status;
	} res_bundle_t;

endpackage

/* design/ppm_stream_to_grayscale.sv */
// Top level of the binary PPM to grayscale stream converter.
// Usage:
//   The input channel takes the file one byte per item (in_byte, in_last on
//   the final byte). Header bytes "P6\n", width, space, height, newline and
//   "255\n" are echoed; each RGB pixel gives its gray value three times.
//   Errors give one item with out_byte 0, out_last 1 and a nonzero status.
//   gray_method (APB register 0, bit 0) picks average or 21/71/8 luminance.
// Timing:
//   An accepted item is held in the input register; its first result
//   is on the output channel the cycle after it leaves that register.
//   Red and green bytes go at one item per cycle, header bytes too while
//   out_stall is low. A blue byte loads three results into the result
//   register, which drains them while the next red and green bytes go on.
// Reset clears the parser to the start of a file and gray_method to 0.
// With out_stall high, results hold; the input register fills and in_stall
// rises only when the next item itself needs the result register.
`include "ppm_stream_to_grayscale_macros.svh"

module ppm_stream_to_grayscale #(
	parameter int DIM_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ppmgray_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        gray_method_q;
	logic        adv, load_ok, res_load;
	res_bundle_t res;

	assign pready   = 1'b1;
	assign prdata   = {31'd0, gray_method_q};
	assign in_stall = valid_s1 && !adv;
	assign res_load = adv && (res.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_method_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
			gray_method_q <= pwdata[0];
		end else if (psel && penable && pwrite && pready) begin
			// byte offsets inside register 0 still address it
			gray_method_q <= pwdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	ppmgray_parse #(
		.DIM_BITS (DIM_BITS)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (valid_s1),
		.item_byte   (byte_s1),
		.item_last   (last_s1),
		.gray_method (gray_method_q),
		.load_ok     (load_ok),
		.adv         (adv),
		.res         (res)
	);

	ppmgray_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res       (res),
		.out_stall (out_stall),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.status    (status)
	);

	`PPMG_ASSERT_NOW(a_err_item_shape, out_valid && status != ST_OK, out_last && out_byte == 8'd0)
	`PPMG_ASSERT_NOW(a_load_when_free, res_load, load_ok)
	`PPMG_ASSERT_NEXT(a_held_item_kept, in_stall, valid_s1)
endmodule

/* design/ppmgray_gray.sv */
// Gray value of one pixel from the partial channel sums and the blue byte.
module ppmgray_gray (
	input  logic [9:0]  avg_part,
	input  logic [14:0] lum_part,
	input  logic [7:0]  blue,
	input  logic        method,
	output logic [7:0]  gray
);
	logic [9:0]  avg_sum;
	logic [14:0] lum_sum;
	logic [19:0] avg_prod;
	logic [27:0] lum_prod;

	assign avg_sum = avg_part + {2'b00, blue};
	assign lum_sum = lum_part + {4'b0000, blue, 3'b000};

	// x/3 as (x*683)>>11 for x <= 765, x/100 as (x*5243)>>19 for x <= 25500
	assign avg_prod = {10'd0, avg_sum} * 20'd683;
	assign lum_prod = {13'd0, lum_sum} * 28'd5243;

	assign gray = method ? lum_prod[26:19] : avg_prod[18:11];
endmodule

/* design/ppmgray_parse.sv */
// Header parser, pixel counter and result bundle generation.
module ppmgray_parse #(
	parameter int DIM_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic [7:0]                item_byte,
	input  logic                      item_last,
	input  logic                      gray_method,
	input  logic                      load_ok,
	output logic                      adv,
	output ppmgray_pkg::res_bundle_t  res
);
	import ppmgray_pkg::*;

	localparam int BLW = 2 * DIM_BITS + 2;
	localparam int TW  = 2 * DIM_BITS;

	localparam logic [2:0] PH_MAGIC  = 3'd0;
	localparam logic [2:0] PH_WIDTH  = 3'd1;
	localparam logic [2:0] PH_HEIGHT = 3'd2;
	localparam logic [2:0] PH_MAXVAL = 3'd3;
	localparam logic [2:0] PH_PIXELS = 3'd4;
	localparam logic [2:0] PH_TAIL   = 3'd5;
	localparam logic [2:0] PH_SKIP   = 3'd6;

	localparam logic [7:0] CH_P  = 8'h50;
	localparam logic [7:0] CH_6  = 8'h36;
	localparam logic [7:0] CH_2  = 8'h32;
	localparam logic [7:0] CH_5  = 8'h35;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_LF = 8'h0a;

	logic [2:0]          phase_q, phase_d;
	logic [1:0]          hpos_q, hpos_d;
	logic [DIM_BITS-1:0] width_q, width_d, height_q, height_d;
	logic [TW-1:0]       total_q;
	logic [BLW-1:0]      bytes_left_q, bytes_left_d;
	logic [1:0]          chan_q, chan_d;
	logic [9:0]          avg_q, avg_d;
	logic [14:0]         lum_q, lum_d;

	logic [7:0]            magic_exp, maxval_exp;
	logic                  is_digit;
	logic [DIM_BITS+3:0]   dig_src, dig_val;
	logic                  dig_ovf;
	logic [14:0]           b_ext;
	logic [7:0]            gray;
	logic                  echo, echo_last, err, restart, gray_emit, gray_last;
	logic [1:0]            err_st;

	assign magic_exp  = (hpos_q == 2'd0) ? CH_P : (hpos_q == 2'd1) ? CH_6 : CH_LF;
	assign maxval_exp = (hpos_q == 2'd0) ? CH_2 : (hpos_q == 2'd3) ? CH_LF : CH_5;

	assign is_digit = (item_byte >= CH_0) && (item_byte <= CH_9);
	assign dig_src  = {4'b0000, (phase_q == PH_WIDTH) ? width_q : height_q};
	assign dig_val  = (dig_src << 3) + (dig_src << 1)
	                + {{(DIM_BITS){1'b0}}, item_byte[3:0]};
	assign dig_ovf  = |dig_val[DIM_BITS+3:DIM_BITS];

	assign b_ext = {7'd0, item_byte};

	ppmgray_gray u_gray (
		.avg_part (avg_q),
		.lum_part (lum_q),
		.blue     (item_byte),
		.method   (gray_method),
		.gray     (gray)
	);

	always_comb begin
		phase_d      = phase_q;
		hpos_d       = hpos_q;
		width_d      = width_q;
		height_d     = height_q;
		bytes_left_d = bytes_left_q;
		chan_d       = chan_q;
		avg_d        = avg_q;
		lum_d        = lum_q;
		echo         = 1'b0;
		echo_last    = 1'b0;
		err          = 1'b0;
		err_st       = ST_HDR;
		restart      = 1'b0;
		gray_emit    = 1'b0;
		gray_last    = 1'b0;
		case (phase_q)
			PH_MAGIC: begin
				if (item_byte != magic_exp) begin
					err = 1'b1;
				end else begin
					echo = 1'b1;
					if (hpos_q == 2'd2) begin
						phase_d = PH_WIDTH;
						hpos_d  = 2'd0;
					end else begin
						hpos_d = hpos_q + 2'd1;
					end
					if (item_last) err = 1'b1;
				end
			end
			PH_WIDTH, PH_HEIGHT: begin
				if (is_digit) begin
					if (dig_ovf) begin
						err = 1'b1;
					end else begin
						echo = 1'b1;
						if (phase_q == PH_WIDTH) width_d = dig_val[DIM_BITS-1:0];
						else height_d = dig_val[DIM_BITS-1:0];
					end
				end else if (phase_q == PH_WIDTH && item_byte == CH_SP) begin
					echo    = 1'b1;
					phase_d = PH_HEIGHT;
				end else if (phase_q == PH_HEIGHT && item_byte == CH_LF) begin
					echo    = 1'b1;
					phase_d = PH_MAXVAL;
					hpos_d  = 2'd0;
				end else begin
					err = 1'b1;
				end
				if (echo && item_last) err = 1'b1;
			end
			PH_MAXVAL: begin
				if (item_byte != maxval_exp) begin
					err = 1'b1;
				end else if (hpos_q != 2'd3) begin
					echo   = 1'b1;
					hpos_d = hpos_q + 2'd1;
					if (item_last) err = 1'b1;
				end else begin
					echo         = 1'b1;
					bytes_left_d = ({{2{1'b0}}, total_q} << 1) + {{2{1'b0}}, total_q};
					chan_d       = 2'd0;
					if (total_q == '0) begin
						// empty image: the newline ends the file
						echo_last = item_last;
						phase_d   = PH_TAIL;
						restart   = item_last;
					end else begin
						phase_d = PH_PIXELS;
						if (item_last) begin
							err    = 1'b1;
							err_st = ST_LEN;
						end
					end
				end
			end
			PH_PIXELS: begin
				if (item_last && bytes_left_q > BLW'(1)) begin
					err    = 1'b1;
					err_st = ST_LEN;
				end else begin
					bytes_left_d = bytes_left_q - BLW'(1);
					case (chan_q)
						2'd0: begin
							avg_d  = {2'b00, item_byte};
							lum_d  = (b_ext << 4) + (b_ext << 2) + b_ext;
							chan_d = 2'd1;
						end
						2'd1: begin
							avg_d  = avg_q + {2'b00, item_byte};
							lum_d  = lum_q + (b_ext << 6) + (b_ext << 2) + (b_ext << 1) + b_ext;
							chan_d = 2'd2;
						end
						default: begin
							gray_emit = 1'b1;
							gray_last = (bytes_left_d == '0) && item_last;
							chan_d    = 2'd0;
						end
					endcase
					if (bytes_left_d == '0) begin
						phase_d = PH_TAIL;
						restart = item_last;
					end
				end
			end
			PH_TAIL: begin
				err    = 1'b1;
				err_st = ST_LEN;
			end
			PH_SKIP: begin
				restart = item_last;
			end
			default: begin
				restart = 1'b1;
			end
		endcase
		if (err || restart) begin
			phase_d      = (err && !item_last) ? PH_SKIP : PH_MAGIC;
			hpos_d       = 2'd0;
			width_d      = '0;
			height_d     = '0;
			bytes_left_d = '0;
			chan_d       = 2'd0;
			avg_d        = '0;
			lum_d        = '0;
		end
	end

	always_comb begin
		res = '0;
		if (gray_emit) begin
			res.n          = 2'd3;
			res.first_byte = gray;
			res.fin_byte   = gray;
			res.fin_last   = gray_last;
			res.fin_status = ST_OK;
		end else if (echo && err) begin
			res.n          = 2'd2;
			res.first_byte = item_byte;
			res.fin_byte   = 8'd0;
			res.fin_last   = 1'b1;
			res.fin_status = err_st;
		end else if (echo) begin
			res.n          = 2'd1;
			res.fin_byte   = item_byte;
			res.fin_last   = echo_last;
			res.fin_status = ST_OK;
		end else if (err) begin
			res.n          = 2'd1;
			res.fin_byte   = 8'd0;
			res.fin_last   = 1'b1;
			res.fin_status = err_st;
		end
	end

	// items without results never wait for the result register
	assign adv = item_valid && ((res.n == 2'd0) || load_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MAGIC;
			hpos_q       <= 2'd0;
			width_q      <= '0;
			height_q     <= '0;
			bytes_left_q <= '0;
			chan_q       <= 2'd0;
			avg_q        <= '0;
			lum_q        <= '0;
		end else if (adv) begin
			phase_q      <= phase_d;
			hpos_q       <= hpos_d;
			width_q      <= width_d;
			height_q     <= height_d;
			bytes_left_q <= bytes_left_d;
			chan_q       <= chan_d;
			avg_q        <= avg_d;
			lum_q        <= lum_d;
		end
	end

	// pixel count, ready well before the closing newline of the header
	always_ff @(posedge clk) begin
		if (adv && phase_q == PH_MAXVAL) begin
			total_q <= TW'(width_q) * TW'(height_q);
		end
	end
endmodule

/* design/ppmgray_emit.sv */
// Result register: holds one bundle and hands out its results one per cycle while out_stall is low.
module ppmgray_emit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  ppmgray_pkg::res_bundle_t res,
	input  logic                     out_stall,
	output logic                     load_ok,
	output logic                     out_valid,
	output logic [7:0]               out_byte,
	output logic                     out_last,
	output logic [1:0]               status
);
	import ppmgray_pkg::*;

	logic [1:0] cnt_q;
	logic [7:0] first_byte_q, fin_byte_q;
	logic       fin_last_q;
	logic [1:0] fin_status_q;
	logic       out_accept;

	assign out_valid  = (cnt_q != 2'd0);
	assign out_accept = out_valid && !out_stall;
	assign load_ok    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_accept);

	assign out_byte = (cnt_q == 2'd1) ? fin_byte_q : first_byte_q;
	assign out_last = (cnt_q == 2'd1) ? fin_last_q : 1'b0;
	assign status   = (cnt_q == 2'd1) ? fin_status_q : ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.n;
		end else if (out_accept) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			first_byte_q <= res.first_byte;
			fin_byte_q   <= res.fin_byte;
			fin_last_q   <= res.fin_last;
			fin_status_q <= res.fin_status;
		end
	end
endmodule
